>>> rtl/tsrm_pkg.sv
`default_nettype none
package tsrm_pkg;

  // field widths
  localparam int unsigned CMD_W   = 8;
  localparam int unsigned LIMIT_W = 8;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned RAW_W   = 16;
  localparam int unsigned BIT_W   = 4;
  localparam int unsigned PHASE_W = 5;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned CFG_W   = 16;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_TEMP_CMD  = 3'd0;
  localparam logic [IDX_W-1:0] REG_HUM_CMD   = 3'd1;
  localparam logic [IDX_W-1:0] REG_POLL_LIM  = 3'd2;
  localparam logic [IDX_W-1:0] REG_POLL_INT  = 3'd3;
  localparam logic [IDX_W-1:0] REG_CLK_HOLD  = 3'd4;

  // configuration reset values
  localparam logic [CMD_W-1:0]   RST_TEMP_CMD = 8'd3;
  localparam logic [CMD_W-1:0]   RST_HUM_CMD  = 8'd5;
  localparam logic [LIMIT_W-1:0] RST_POLL_LIM = 8'd100;
  localparam logic [TICK_W-1:0]  RST_POLL_INT = 16'd10;
  localparam logic [TICK_W-1:0]  RST_CLK_HOLD = 16'd10;

  // sequencer phase codes
  localparam logic [PHASE_W-1:0] PH_IDLE  = 5'd0;
  localparam logic [PHASE_W-1:0] PH_ST0   = 5'd1;
  localparam logic [PHASE_W-1:0] PH_TX_LO = 5'd8;
  localparam logic [PHASE_W-1:0] PH_TX_HI = 5'd9;
  localparam logic [PHASE_W-1:0] PH_AK_HI = 5'd10;
  localparam logic [PHASE_W-1:0] PH_AK_LO = 5'd11;
  localparam logic [PHASE_W-1:0] PH_POLL  = 5'd12;
  localparam logic [PHASE_W-1:0] PH_RD_HI = 5'd13;
  localparam logic [PHASE_W-1:0] PH_RD_LO = 5'd14;
  localparam logic [PHASE_W-1:0] PH_MA0   = 5'd15;
  localparam logic [PHASE_W-1:0] PH_EN0   = 5'd19;
  localparam logic [PHASE_W-1:0] PH_LAST  = 5'd21;

  // line patterns, bit k is step k
  localparam logic [6:0] START_DATA = 7'b1100011;
  localparam logic [6:0] START_CLK  = 7'b0110110;
  localparam logic [3:0] MACK_DATA  = 4'b0001;
  localparam logic [3:0] MACK_CLK   = 4'b0100;
  localparam logic [3:0] END_CLK    = 4'b0010;

  typedef struct packed {
    logic [CMD_W-1:0]   temperature_command;
    logic [CMD_W-1:0]   humidity_command;
    logic [LIMIT_W-1:0] poll_limit;
    logic [TICK_W-1:0]  poll_interval;
    logic [TICK_W-1:0]  clock_high_hold;
  } cfg_t;

  typedef struct packed {
    logic req_type;
    logic sel_humidity;
    logic data_line_in;
  } item_t;

  typedef struct packed {
    logic             clock_out;
    logic             data_drive_enable;
    logic             data_out;
    logic             busy_res;
    logic             done_res;
    logic [RAW_W-1:0] raw_value;
    logic             result_is_humidity;
    logic             ack_error;
    logic             timeout_error;
  } res_t;

endpackage
`default_nettype wire

>>> rtl/tsrm_if.sv
`default_nettype none
interface tsrm_in_if;
  logic valid;
  logic ready;
  logic req_type;
  logic sel_humidity;
  logic data_line_in;
  modport source (output valid, req_type, sel_humidity, data_line_in, input ready);
  modport sink (input valid, req_type, sel_humidity, data_line_in, output ready);
endinterface

interface tsrm_out_if import tsrm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             clock_out;
  logic             data_drive_enable;
  logic             data_out;
  logic             busy_res;
  logic             done_res;
  logic [RAW_W-1:0] raw_value;
  logic             result_is_humidity;
  logic             ack_error;
  logic             timeout_error;
  modport source (output valid, clock_out, data_drive_enable, data_out, busy_res,
                  done_res, raw_value, result_is_humidity, ack_error, timeout_error,
                  input ready);
  modport sink (input valid, clock_out, data_drive_enable, data_out, busy_res,
                done_res, raw_value, result_is_humidity, ack_error, timeout_error,
                output ready);
endinterface

interface tsrm_cfg_if import tsrm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [CFG_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/two_wire_sensor_read_master_unit.sv
// channel  dir  handshake      payload
// in_ch    in   valid / ready  req_type, sel_humidity, data_line_in
// out_ch   out  valid / ready  line drive, busy/done, raw_value, hum flag, errors
// cfg_ch   in   valid / ready  index (3 bit), data (16 bit)
//
// one item per cycle sustained while the result sink keeps up; a result follows its item
// through the input register, one sequencer pass and the result register
// the sequencer state loop closes through its state registers alone, which sets the rate
// synchronous active-low reset: sequencer idle, registers to their defaults
// a stalled result holds in the output register; the input register keeps
// taking items until it is full too
`default_nettype none
module two_wire_sensor_read_master_unit import tsrm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  tsrm_in_if.sink   in_ch,
  tsrm_out_if.source out_ch,
  tsrm_cfg_if.sink  cfg_ch
);

  logic  in_v_r;
  item_t in_item_r;
  logic  out_v_r;
  res_t  out_res_r;
  logic  advance;
  cfg_t  cfg;
  res_t  res;

  assign advance     = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || advance;

  tsrm_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  tsrm_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .item  (in_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item_r.req_type     <= in_ch.req_type;
      in_item_r.sel_humidity <= in_ch.sel_humidity;
      in_item_r.data_line_in <= in_ch.data_line_in;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid              = out_v_r;
  assign out_ch.clock_out          = out_res_r.clock_out;
  assign out_ch.data_drive_enable  = out_res_r.data_drive_enable;
  assign out_ch.data_out           = out_res_r.data_out;
  assign out_ch.busy_res           = out_res_r.busy_res;
  assign out_ch.done_res           = out_res_r.done_res;
  assign out_ch.raw_value          = out_res_r.raw_value;
  assign out_ch.result_is_humidity = out_res_r.result_is_humidity;
  assign out_ch.ack_error          = out_res_r.ack_error;
  assign out_ch.timeout_error      = out_res_r.timeout_error;

endmodule
`default_nettype wire

>>> rtl/tsrm_cfg.sv
`default_nettype none
module tsrm_cfg import tsrm_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  tsrm_cfg_if.sink    cfg_ch,
  output cfg_t        cfg
);

  cfg_t regs_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg = regs_r;

  // register writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.temperature_command <= RST_TEMP_CMD;
      regs_r.humidity_command    <= RST_HUM_CMD;
      regs_r.poll_limit          <= RST_POLL_LIM;
      regs_r.poll_interval       <= RST_POLL_INT;
      regs_r.clock_high_hold     <= RST_CLK_HOLD;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_TEMP_CMD: regs_r.temperature_command <= cfg_ch.data[CMD_W-1:0];
        REG_HUM_CMD:  regs_r.humidity_command    <= cfg_ch.data[CMD_W-1:0];
        REG_POLL_LIM: regs_r.poll_limit          <= cfg_ch.data[LIMIT_W-1:0];
        REG_POLL_INT: regs_r.poll_interval       <= cfg_ch.data[TICK_W-1:0];
        REG_CLK_HOLD: regs_r.clock_high_hold     <= cfg_ch.data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/tsrm_core.sv
`default_nettype none
module tsrm_core import tsrm_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  fire,
  input  wire item_t item,
  input  wire cfg_t  cfg,
  output res_t       res
);

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [BIT_W-1:0]   bit_r, bit_nxt;
  logic [RAW_W-1:0]   shift_r, shift_nxt;
  logic [TICK_W-1:0]  tick_r, tick_nxt;
  logic [LIMIT_W-1:0] poll_r, poll_nxt;
  logic               sel_r, sel_nxt;
  logic [1:0]         err_r, err_nxt;

  logic [PHASE_W-1:0] cur;
  logic [PHASE_W-1:0] k_st, k_ma, k_en;
  logic [TICK_W-1:0]  interval_eff, hold_eff;
  logic [LIMIT_W-1:0] limit_eff;
  logic [TICK_W:0]    tick_inc;
  logic [LIMIT_W-1:0] poll_inc;
  logic               clk_o, en_o, dout_o, done_o, hum_o;
  logic [RAW_W-1:0]   raw_o;

  // zero intervals and limits behave as one
  assign interval_eff = (cfg.poll_interval == '0) ? TICK_W'(1) : cfg.poll_interval;
  assign hold_eff     = (cfg.clock_high_hold == '0) ? TICK_W'(1) : cfg.clock_high_hold;
  assign limit_eff    = (cfg.poll_limit == '0) ? LIMIT_W'(1) : cfg.poll_limit;
  assign tick_inc     = {1'b0, tick_r} + (TICK_W+1)'(1);
  assign poll_inc     = poll_r + LIMIT_W'(1);

  // one tick of the sequencer
  always_comb begin
    phase_nxt = phase_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    tick_nxt  = tick_r;
    poll_nxt  = poll_r;
    sel_nxt   = sel_r;
    err_nxt   = err_r;
    clk_o     = 1'b0;
    en_o      = 1'b0;
    dout_o    = 1'b0;
    done_o    = 1'b0;
    hum_o     = 1'b0;
    raw_o     = '0;

    cur = (phase_r > PH_LAST) ? PH_IDLE : phase_r;
    if ((cur == PH_IDLE) && item.req_type) begin
      sel_nxt   = item.sel_humidity;
      err_nxt   = '0;
      shift_nxt = {8'd0, item.sel_humidity ? cfg.humidity_command
                                             : cfg.temperature_command};
      bit_nxt   = '0;
      tick_nxt  = '0;
      poll_nxt  = '0;
      cur       = PH_ST0;
    end
    phase_nxt = cur;
    k_st = cur - PH_ST0;
    k_ma = cur - PH_MA0;
    k_en = cur - PH_EN0;

    priority if ((cur >= PH_ST0) && (cur < PH_TX_LO)) begin
      en_o      = 1'b1;
      dout_o    = START_DATA[k_st[2:0]];
      clk_o     = START_CLK[k_st[2:0]];
      phase_nxt = cur + PHASE_W'(1);
    end else if ((cur == PH_TX_LO) || (cur == PH_TX_HI)) begin
      en_o   = 1'b1;
      dout_o = shift_nxt[7];
      if (cur == PH_TX_LO) begin
        phase_nxt = PH_TX_HI;
      end else begin
        clk_o     = 1'b1;
        shift_nxt = {8'd0, shift_nxt[6:0], 1'b0};
        if (bit_nxt >= BIT_W'(7)) begin
          bit_nxt   = '0;
          phase_nxt = PH_AK_HI;
        end else begin
          bit_nxt   = bit_nxt + BIT_W'(1);
          phase_nxt = PH_TX_LO;
        end
      end
    end else if (cur == PH_AK_HI) begin
      clk_o = 1'b1;
      if (item.data_line_in) err_nxt[0] = 1'b1;
      phase_nxt = PH_AK_LO;
    end else if (cur == PH_AK_LO) begin
      if (!item.data_line_in) err_nxt[0] = 1'b1;
      tick_nxt  = '0;
      poll_nxt  = '0;
      phase_nxt = PH_POLL;
    end else if (cur == PH_POLL) begin
      tick_nxt = tick_inc[TICK_W-1:0];
      if (tick_inc >= {1'b0, interval_eff}) begin
        tick_nxt = '0;
        if (!item.data_line_in) begin
          shift_nxt = '0;
          bit_nxt   = '0;
          phase_nxt = PH_RD_HI;
        end else begin
          poll_nxt = poll_inc;
          if ((poll_inc == '0) || (poll_inc >= limit_eff)) begin
            err_nxt[1] = 1'b1;
            done_o     = 1'b1;
            hum_o      = sel_nxt;
            phase_nxt  = PH_IDLE;
          end
        end
      end
    end else if (cur == PH_RD_HI) begin
      clk_o    = 1'b1;
      tick_nxt = tick_inc[TICK_W-1:0];
      if (tick_inc >= {1'b0, hold_eff}) begin
        tick_nxt  = '0;
        shift_nxt = {shift_nxt[RAW_W-2:0], item.data_line_in};
        phase_nxt = PH_RD_LO;
      end
    end else if (cur == PH_RD_LO) begin
      priority if (bit_nxt == BIT_W'(7)) begin
        bit_nxt   = BIT_W'(8);
        phase_nxt = PH_MA0;
      end else if (bit_nxt >= BIT_W'(15)) begin
        bit_nxt   = '0;
        phase_nxt = PH_EN0;
      end else begin
        bit_nxt   = bit_nxt + BIT_W'(1);
        phase_nxt = PH_RD_HI;
      end
    end else if ((cur >= PH_MA0) && (cur < PH_EN0)) begin
      en_o      = 1'b1;
      dout_o    = MACK_DATA[k_ma[1:0]];
      clk_o     = MACK_CLK[k_ma[1:0]];
      phase_nxt = (k_ma[1:0] == 2'd3) ? PH_RD_HI : cur + PHASE_W'(1);
    end else if (cur >= PH_EN0) begin
      en_o   = 1'b1;
      dout_o = 1'b1;
      clk_o  = END_CLK[k_en[1:0]];
      if (k_en[1:0] == 2'd2) begin
        done_o    = 1'b1;
        raw_o     = shift_nxt;
        hum_o     = sel_nxt;
        phase_nxt = PH_IDLE;
      end else begin
        phase_nxt = cur + PHASE_W'(1);
      end
    end else begin
      phase_nxt = PH_IDLE;
    end
  end

  // result of this tick
  always_comb begin
    res.clock_out          = clk_o;
    res.data_drive_enable  = en_o;
    res.data_out           = en_o & dout_o;
    res.busy_res           = (cur != PH_IDLE);
    res.done_res           = done_o;
    res.raw_value          = raw_o;
    res.result_is_humidity = hum_o;
    res.ack_error          = err_nxt[0];
    res.timeout_error      = err_nxt[1];
  end

  // sequencer state, advances once per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      bit_r   <= '0;
      shift_r <= '0;
      tick_r  <= '0;
      poll_r  <= '0;
      sel_r   <= 1'b0;
      err_r   <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      tick_r  <= tick_nxt;
      poll_r  <= poll_nxt;
      sel_r   <= sel_nxt;
      err_r   <= err_nxt;
    end
  end

  // checks
  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.done_res) |=> (phase_r == PH_IDLE))
    else $error("done without return to idle");

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res.done_res |-> res.busy_res)
    else $error("done outside a measurement");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> ($stable(phase_r) && $stable(shift_r) && $stable(err_r)))
    else $error("state moved without an item");

  a_tx_bits: assert property (@(posedge clk) disable iff (!rst_n)
    ((phase_r == PH_TX_LO) || (phase_r == PH_TX_HI)) |-> (bit_r <= BIT_W'(7)))
    else $error("command bit count out of range");

endmodule
`default_nettype wire

>>> tb/sv/two_wire_sensor_read_master_unit_tb.sv
`timescale 1ns / 1ps
module two_wire_sensor_read_master_unit_tb;
  import tsrm_pkg::*;

  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;

  // unused register slots of the index field
  localparam logic [IDX_W-1:0] REG_NONE_LO = 3'd5;
  localparam logic [IDX_W-1:0] REG_NONE_HI = 3'd7;

  // bus patterns, bit k is step k
  localparam logic [6:0] PREAMBLE_DATA = 7'b1100011;
  localparam logic [6:0] PREAMBLE_CLK  = 7'b0110110;
  localparam logic [3:0] MACK_DATA_SEQ = 4'b0001;
  localparam logic [3:0] MACK_CLK_SEQ  = 4'b0100;

  localparam logic TYPED     = 1'b1;
  localparam logic PREDICTED = 1'b0;

  typedef enum logic [1:0] {ANSWER_OK, ANSWER_NO_ACK, ANSWER_SILENT} sensor_plan_t;

  typedef struct packed {
    logic  typed;
    item_t stim;
    res_t  want;
  } dir_row_t;

  // directed rows: {typed, {req, sel, din}, {clk, en, dout, busy, done}, raw, {hum, ack, tmo}}
  localparam dir_row_t [0:25] DIRECTED_ROWS = {
    // plain tick in idle
    {TYPED,     3'b001, 5'b00000, 16'h0000, 3'b000},
    // humidity request, then the start sequence
    {TYPED,     3'b110, 5'b01110, 16'h0000, 3'b000},
    {TYPED,     3'b001, 5'b11110, 16'h0000, 3'b000},
    // request while busy is ignored
    {TYPED,     3'b101, 5'b11010, 16'h0000, 3'b000},
    {TYPED,     3'b000, 5'b01010, 16'h0000, 3'b000},
    {TYPED,     3'b011, 5'b11010, 16'h0000, 3'b000},
    {TYPED,     3'b100, 5'b11110, 16'h0000, 3'b000},
    {TYPED,     3'b001, 5'b01110, 16'h0000, 3'b000},
    // command byte, msb first
    {PREDICTED, 3'b000, 24'd0}, {PREDICTED, 3'b001, 24'd0},
    {PREDICTED, 3'b010, 24'd0}, {PREDICTED, 3'b011, 24'd0},
    {PREDICTED, 3'b100, 24'd0}, {PREDICTED, 3'b101, 24'd0},
    {PREDICTED, 3'b110, 24'd0}, {PREDICTED, 3'b111, 24'd0},
    {PREDICTED, 3'b001, 24'd0}, {PREDICTED, 3'b100, 24'd0},
    {PREDICTED, 3'b011, 24'd0}, {PREDICTED, 3'b110, 24'd0},
    {PREDICTED, 3'b000, 24'd0}, {PREDICTED, 3'b111, 24'd0},
    {PREDICTED, 3'b010, 24'd0}, {PREDICTED, 3'b101, 24'd0},
    // sensor misses both halves of the ack
    {TYPED,     3'b001, 5'b10010, 16'h0000, 3'b010},
    {TYPED,     3'b000, 5'b00010, 16'h0000, 3'b010}
  };

  logic clk;
  logic rst_n;

  tsrm_in_if  in_ch ();
  tsrm_out_if out_ch ();
  tsrm_cfg_if cfg_ch ();

  two_wire_sensor_read_master_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // master state mirror and register shadow
  cfg_t         m_cfg;
  logic [4:0]   m_phase;
  logic [3:0]   m_bits;
  logic [15:0]  m_shift;
  logic [15:0]  m_ticks;
  logic [7:0]   m_polls;
  logic         m_sel;
  logic [1:0]   m_err;

  // sensor behavior for the measurement in flight
  sensor_plan_t plan;
  sensor_plan_t fixed_plan;
  bit           plan_fixed;
  logic [1:0]   ack_faults;

  res_t due_ticks[$];
  bit   calm;
  int   mismatches;
  int   n_ticks;
  int   n_checked;
  int   n_readings;
  int   n_timeouts;
  int   n_ack_faults;
  int   n_cfg_writes;

  function automatic logic [15:0] floor_one(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one tick of the bit-banged master
  task automatic master_tick(input item_t it, output res_t r);
    logic [4:0] k;
    r = '0;
    if (m_phase > PH_LAST) m_phase = PH_IDLE;
    if (m_phase == PH_IDLE && it.req_type) begin
      m_sel   = it.sel_humidity;
      m_err   = 2'b00;
      m_shift = {8'h00, it.sel_humidity ? m_cfg.humidity_command : m_cfg.temperature_command};
      m_bits  = 4'd0;
      m_ticks = 16'd0;
      m_polls = 8'd0;
      m_phase = PH_ST0;
    end
    r.busy_res = (m_phase != PH_IDLE);

    if (m_phase >= PH_ST0 && m_phase < PH_TX_LO) begin
      // start sequence
      k = m_phase - PH_ST0;
      r.data_drive_enable = 1'b1;
      r.data_out  = PREAMBLE_DATA[k];
      r.clock_out = PREAMBLE_CLK[k];
      m_phase = m_phase + 5'd1;
    end else if (m_phase == PH_TX_LO || m_phase == PH_TX_HI) begin
      // command bit, low half then high half
      r.data_drive_enable = 1'b1;
      r.data_out = m_shift[7];
      if (m_phase == PH_TX_LO) begin
        m_phase = PH_TX_HI;
      end else begin
        r.clock_out = 1'b1;
        m_shift = {8'h00, m_shift[6:0], 1'b0};
        if (m_bits >= 4'd7) begin
          m_bits  = 4'd0;
          m_phase = PH_AK_HI;
        end else begin
          m_bits  = m_bits + 4'd1;
          m_phase = PH_TX_LO;
        end
      end
    end else if (m_phase == PH_AK_HI) begin
      r.clock_out = 1'b1;
      if (it.data_line_in) m_err[0] = 1'b1;
      m_phase = PH_AK_LO;
    end else if (m_phase == PH_AK_LO) begin
      if (!it.data_line_in) m_err[0] = 1'b1;
      m_ticks = 16'd0;
      m_polls = 8'd0;
      m_phase = PH_POLL;
    end else if (m_phase == PH_POLL) begin
      // wait for the sensor to pull data low
      m_ticks = m_ticks + 16'd1;
      if (m_ticks >= floor_one(m_cfg.poll_interval)) begin
        m_ticks = 16'd0;
        if (!it.data_line_in) begin
          m_shift = 16'd0;
          m_bits  = 4'd0;
          m_phase = PH_RD_HI;
        end else begin
          m_polls = m_polls + 8'd1;
          if (m_polls == 8'd0 ||
              {8'h00, m_polls} >= floor_one({8'h00, m_cfg.poll_limit})) begin
            m_err[1] = 1'b1;
            r.done_res = 1'b1;
            r.result_is_humidity = m_sel;
            m_phase = PH_IDLE;
          end
        end
      end
    end else if (m_phase == PH_RD_HI) begin
      r.clock_out = 1'b1;
      m_ticks = m_ticks + 16'd1;
      if (m_ticks >= floor_one(m_cfg.clock_high_hold)) begin
        m_ticks = 16'd0;
        m_shift = {m_shift[14:0], it.data_line_in};
        m_phase = PH_RD_LO;
      end
    end else if (m_phase == PH_RD_LO) begin
      if (m_bits == 4'd7) begin
        m_bits  = 4'd8;
        m_phase = PH_MA0;
      end else if (m_bits >= 4'd15) begin
        m_bits  = 4'd0;
        m_phase = PH_EN0;
      end else begin
        m_bits  = m_bits + 4'd1;
        m_phase = PH_RD_HI;
      end
    end else if (m_phase >= PH_MA0 && m_phase < PH_EN0) begin
      // master ack between the two bytes
      k = m_phase - PH_MA0;
      r.data_drive_enable = 1'b1;
      r.data_out  = MACK_DATA_SEQ[k];
      r.clock_out = MACK_CLK_SEQ[k];
      m_phase = (k == 5'd3) ? PH_RD_HI : m_phase + 5'd1;
    end else if (m_phase >= PH_EN0) begin
      // frame end, crc skipped
      k = m_phase - PH_EN0;
      r.data_drive_enable = 1'b1;
      r.data_out  = 1'b1;
      r.clock_out = (k == 5'd1);
      if (k == 5'd2) begin
        r.done_res = 1'b1;
        r.raw_value = m_shift;
        r.result_is_humidity = m_sel;
        m_phase = PH_IDLE;
      end else begin
        m_phase = m_phase + 5'd1;
      end
    end

    r.ack_error = m_err[0];
    r.timeout_error = m_err[1];
  endtask

  // sensor side of the bus, drawn from the master's current step
  task automatic make_tick(input int start_pct, output item_t it);
    int pick;
    it.req_type = 1'b0;
    it.sel_humidity = 1'($urandom);
    it.data_line_in = 1'($urandom);
    if (m_phase == PH_IDLE) begin
      if ($urandom_range(1, 100) <= start_pct) begin
        it.req_type = 1'b1;
        pick = $urandom_range(0, 9);
        if (plan_fixed) plan = fixed_plan;
        else if (pick == 0) plan = ANSWER_NO_ACK;
        else if (pick == 1) plan = ANSWER_SILENT;
        else plan = ANSWER_OK;
        ack_faults = (plan == ANSWER_NO_ACK) ? 2'($urandom_range(1, 3)) : 2'b00;
      end
    end else begin
      it.req_type = ($urandom_range(0, 15) == 0);
      case (m_phase)
        PH_AK_HI: it.data_line_in = ack_faults[0];
        PH_AK_LO: it.data_line_in = !ack_faults[1];
        PH_POLL:  it.data_line_in = (plan == ANSWER_SILENT) ? 1'b1 : ($urandom_range(0, 3) != 0);
        default: ;
      endcase
    end
  endtask

  // drive one item and record its predicted result
  task automatic send_tick(input item_t it, input logic typed, input res_t typed_res);
    int gap;
    res_t r;
    gap = calm ? 0 : idle_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.req_type = it.req_type;
    in_ch.sel_humidity = it.sel_humidity;
    in_ch.data_line_in = it.data_line_in;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    master_tick(it, r);
    due_ticks.push_back(typed ? typed_res : r);
    n_ticks++;
  endtask

  // random traffic, then plain ticks until the master is back in idle
  task automatic run_traffic(input int n, input int start_pct, input bit fixed,
                             input sensor_plan_t fp);
    item_t it;
    plan_fixed = fixed;
    fixed_plan = fp;
    repeat (n) begin
      make_tick(start_pct, it);
      send_tick(it, PREDICTED, '0);
    end
    while (m_phase != PH_IDLE) begin
      make_tick(0, it);
      send_tick(it, PREDICTED, '0);
    end
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (due_ticks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_TEMP_CMD: m_cfg.temperature_command = data[7:0];
      REG_HUM_CMD:  m_cfg.humidity_command = data[7:0];
      REG_POLL_LIM: m_cfg.poll_limit = data[7:0];
      REG_POLL_INT: m_cfg.poll_interval = data;
      REG_CLK_HOLD: m_cfg.clock_high_hold = data;
      default: ;
    endcase
    n_cfg_writes++;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result sink with random stalls, and calm stretches for both sides
  initial begin : result_sink
    int stall;
    int calm_left;
    stall = 0;
    calm_left = 0;
    calm = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (calm_left == 0) begin
        calm = ($urandom_range(0, 3) == 0);
        calm_left = $urandom_range(50, 300);
      end else begin
        calm_left--;
      end
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        stall--;
      end else begin
        out_ch.ready = 1'b1;
        stall = calm ? 0 : idle_gap();
      end
    end
  end

  // compare each result item with the oldest prediction
  always @(posedge clk) begin : result_check
    res_t got;
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.clock_out = out_ch.clock_out;
      got.data_drive_enable = out_ch.data_drive_enable;
      got.data_out = out_ch.data_out;
      got.busy_res = out_ch.busy_res;
      got.done_res = out_ch.done_res;
      got.raw_value = out_ch.raw_value;
      got.result_is_humidity = out_ch.result_is_humidity;
      got.ack_error = out_ch.ack_error;
      got.timeout_error = out_ch.timeout_error;
      if (due_ticks.size() == 0) begin
        $error("result item with no prediction pending");
        mismatches++;
      end else begin
        want = due_ticks.pop_front();
        check_field("clock_out", want.clock_out, got.clock_out);
        check_field("data_drive_enable", want.data_drive_enable, got.data_drive_enable);
        check_field("data_out", want.data_out, got.data_out);
        check_field("busy_res", want.busy_res, got.busy_res);
        check_field("done_res", want.done_res, got.done_res);
        check_field("raw_value", want.raw_value, got.raw_value);
        check_field("result_is_humidity", want.result_is_humidity, got.result_is_humidity);
        check_field("ack_error", want.ack_error, got.ack_error);
        check_field("timeout_error", want.timeout_error, got.timeout_error);
        n_checked++;
        if (want.done_res) begin
          if (want.timeout_error) n_timeouts++;
          else n_readings++;
          if (want.ack_error) n_ack_faults++;
        end
      end
    end
  end

  // watchdog on handshake activity
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
          (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("no handshake for %0d cycles, %0d predictions pending", QUIET_LIMIT,
             due_ticks.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.req_type = 1'b0;
    in_ch.sel_humidity = 1'b0;
    in_ch.data_line_in = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    mismatches = 0;
    n_ticks = 0;
    n_checked = 0;
    n_readings = 0;
    n_timeouts = 0;
    n_ack_faults = 0;
    n_cfg_writes = 0;

    // register defaults and idle master
    m_cfg.temperature_command = 8'd3;
    m_cfg.humidity_command = 8'd5;
    m_cfg.poll_limit = 8'd100;
    m_cfg.poll_interval = 16'd10;
    m_cfg.clock_high_hold = 16'd10;
    m_phase = PH_IDLE;
    m_bits = 4'd0;
    m_shift = 16'd0;
    m_ticks = 16'd0;
    m_polls = 8'd0;
    m_sel = 1'b0;
    m_err = 2'b00;
    plan = ANSWER_OK;
    fixed_plan = ANSWER_OK;
    plan_fixed = 1'b0;
    ack_faults = 2'b00;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table, then the measurement it began runs on at reset settings
    for (int i = 0; i < 26; i++)
      send_tick(DIRECTED_ROWS[i].stim, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    run_traffic(100, 33, 1'b0, ANSWER_OK);

    // fastest timing, extreme commands, single poll
    cfg_write(REG_TEMP_CMD, {8'($urandom), 8'h00});
    cfg_write(REG_HUM_CMD, {8'($urandom), 8'hFF});
    cfg_write(REG_POLL_LIM, {8'($urandom), 8'd1});
    cfg_write(REG_POLL_INT, 16'd1);
    cfg_write(REG_CLK_HOLD, 16'd1);
    run_traffic(100, 33, 1'b0, ANSWER_OK);

    // longest poll count, one silent sensor first
    cfg_write(REG_TEMP_CMD, {8'($urandom), 8'hFF});
    cfg_write(REG_HUM_CMD, {8'($urandom), 8'h00});
    cfg_write(REG_POLL_LIM, {8'($urandom), 8'd255});
    cfg_write(REG_POLL_INT, 16'd1);
    cfg_write(REG_CLK_HOLD, 16'd2);
    run_traffic(1, 100, 1'b1, ANSWER_SILENT);
    run_traffic(80, 33, 1'b0, ANSWER_OK);

    // zero counts behave as one; unused slot ignored
    cfg_write(REG_POLL_LIM, 16'd0);
    cfg_write(REG_POLL_INT, 16'd0);
    cfg_write(REG_CLK_HOLD, 16'd0);
    cfg_write(3'($urandom_range(REG_NONE_LO, REG_NONE_HI)), 16'($urandom));
    run_traffic(80, 33, 1'b0, ANSWER_OK);

    // wide poll interval, sensor never answers
    cfg_write(REG_POLL_LIM, {8'($urandom), 8'd1});
    cfg_write(REG_POLL_INT, 16'h0100);
    cfg_write(REG_CLK_HOLD, 16'hFFFF);
    run_traffic(1, 100, 1'b1, ANSWER_SILENT);

    // random commands with short timing
    repeat (4) begin
      cfg_write(REG_TEMP_CMD, 16'($urandom));
      cfg_write(REG_HUM_CMD, 16'($urandom));
      cfg_write(REG_POLL_LIM, {8'($urandom), 8'($urandom_range(1, 6))});
      cfg_write(REG_POLL_INT, 16'($urandom_range(1, 4)));
      cfg_write(REG_CLK_HOLD, 16'($urandom_range(1, 4)));
      run_traffic(50, 33, 1'b0, ANSWER_OK);
    end

    $display("%0d ticks driven, %0d result items checked, %0d register writes",
             n_ticks, n_checked, n_cfg_writes);
    $display("%0d complete readings, %0d poll timeouts, %0d with ack faults",
             n_readings, n_timeouts, n_ack_faults);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> two_wire_sensor_read_master_unit.f
rtl/tsrm_pkg.sv
rtl/tsrm_if.sv
rtl/tsrm_cfg.sv
rtl/tsrm_core.sv
rtl/two_wire_sensor_read_master_unit.sv
tb/sv/two_wire_sensor_read_master_unit_tb.sv
